// ===== rtl/ftwa_pkg.sv =====
package ftwa_pkg;

    // fixed field widths
    localparam int FIELD_BITS = 32;
    localparam int SUM_BITS   = 33;

    // timestamp and counter widths
    localparam int STAMP_BITS = 32;
    localparam int COUNT_BITS = 16;

    // divider step counter: one quotient bit per step
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_BITS-1:0] THRESHOLD_RESET = FIELD_BITS'(500000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX         = '1;

    // classified frame handed from front to back
    typedef struct packed {
        logic [FIELD_BITS-1:0] delta;
        logic                  done;
        logic [COUNT_BITS-1:0] frames;
        logic [SUM_BITS-1:0]   sum;
        logic [SUM_BITS-1:0]   dividend;
        logic [COUNT_BITS-1:0] divisor;
    } ftwa_job_t;

endpackage

// ===== rtl/ftwa_if.sv =====
interface ftwa_in_if;
    import ftwa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] now_stamp_us;

    modport source (output valid, output now_stamp_us, input ready);
    modport sink   (input valid, input now_stamp_us, output ready);
endinterface

interface ftwa_out_if;
    import ftwa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] delta_us;
    logic                  window_done;
    logic [SUM_BITS-1:0]   average_us;
    logic [COUNT_BITS-1:0] frames_in_window;
    logic [SUM_BITS-1:0]   window_sum_us;

    modport source (output valid, output delta_us, output window_done, output average_us,
                    output frames_in_window, output window_sum_us, input ready);
    modport sink   (input valid, input delta_us, input window_done, input average_us,
                    input frames_in_window, input window_sum_us, output ready);
endinterface

// ===== rtl/frame_time_window_average_top.sv =====
// flow of a frame: combinational front, queue entry, back-end job register, the bit-serial
//   divide for a frame that closes a window, then the registered result transaction
// the back end takes a new frame only after emitting the last one and may wait on result ready;
//   the 2-entry queue lets the front accept frames while the divider runs
// reset: async active low; stamp, count, sum and average clear to zero, threshold to 500000
module frame_time_window_average_top (
    input  logic                            clk,
    input  logic                            rst_n,
    ftwa_in_if.sink                         frame_in,
    ftwa_out_if.source                      result_out,
    input  logic                            cfg_wr_en,
    input  logic [ftwa_pkg::FIELD_BITS-1:0] cfg_wr_data
);
    import ftwa_pkg::*;

    // front to queue
    logic      push_valid;
    logic      push_ready;
    ftwa_job_t push_data;

    // queue to back
    logic      pop_valid;
    logic      pop_ready;
    ftwa_job_t pop_data;

    // front end: takes the frame transaction, computes the wrapped delta, updates the
    // saturating count and sum and decides whether this frame closes a window
    ftwa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (push_valid),
        .job_ready   (push_ready),
        .job         (push_data)
    );

    // short queue so the front keeps its state current while the back divides
    ftwa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: runs the sum / count divide on window close, holds the average
    // and drives the registered result transaction
    ftwa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_pop    (pop_ready),
        .job        (pop_data),
        .result_out (result_out)
    );

endmodule

// ===== rtl/ftwa_front.sv =====
module ftwa_front (
    input  logic                             clk,
    input  logic                             rst_n,
    ftwa_in_if.sink                          frame_in,
    input  logic                             cfg_wr_en,
    input  logic [ftwa_pkg::FIELD_BITS-1:0]  cfg_wr_data,
    output logic                             job_valid,
    input  logic                             job_ready,
    output ftwa_pkg::ftwa_job_t              job
);
    import ftwa_pkg::*;

    logic [STAMP_BITS-1:0] last_stamp_reg, last_stamp_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [FIELD_BITS-1:0] threshold_reg;

    logic [STAMP_BITS-1:0] now;
    logic [STAMP_BITS-1:0] delta;
    logic [COUNT_BITS-1:0] count_inc;
    logic [SUM_BITS:0]     sum_wide;
    logic [SUM_BITS-1:0]   sum_sat;
    logic                  close;
    logic                  accept;

    assign frame_in.ready = job_ready;
    assign accept         = frame_in.valid && job_ready;
    assign job_valid      = frame_in.valid;

    always_comb
    begin
        now       = STAMP_BITS'(frame_in.now_stamp_us);
        delta     = now - last_stamp_reg;
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        sum_wide  = {1'b0, sum_reg} + (SUM_BITS + 1)'(delta);
        sum_sat   = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
        close     = sum_sat >= SUM_BITS'(threshold_reg);

        job.delta    = FIELD_BITS'(delta);
        job.done     = close;
        job.frames   = close ? '0 : count_inc;
        job.sum      = close ? '0 : sum_sat;
        job.dividend = sum_sat;
        job.divisor  = count_inc;

        last_stamp_next = accept ? now : last_stamp_reg;
        count_next      = accept ? job.frames : count_reg;
        sum_next        = accept ? job.sum : sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            threshold_reg  <= THRESHOLD_RESET;
        end
        else
        begin
            last_stamp_reg <= last_stamp_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/ftwa_queue.sv =====
module ftwa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  ftwa_pkg::ftwa_job_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ftwa_pkg::ftwa_job_t pop_data
);
    import ftwa_pkg::*;

    ftwa_job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   push;
    logic                   pop;

    assign push_ready = cnt_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== rtl/ftwa_back.sv =====
module ftwa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_pop,
    input  ftwa_pkg::ftwa_job_t job,
    ftwa_out_if.source          result_out
);
    import ftwa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    ftwa_job_t               job_reg;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [SUM_BITS-1:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] step_reg;
    logic [SUM_BITS-1:0]     avg_reg;
    logic                    out_valid_reg;
    logic [FIELD_BITS-1:0]   out_delta_reg;
    logic                    out_done_reg;
    logic [SUM_BITS-1:0]     out_avg_reg;
    logic [COUNT_BITS-1:0]   out_frames_reg;
    logic [SUM_BITS-1:0]     out_sum_reg;

    logic [COUNT_BITS:0]     trial;
    logic                    take;
    logic [COUNT_BITS-1:0]   rem_step;
    logic [SUM_BITS-1:0]     quo_step;
    logic                    last_step;
    logic                    emit_ok;
    logic                    load_out;

    // one restoring division step per cycle, msb first
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_BITS-1]};
        take      = trial >= {1'b0, job_reg.divisor};
        rem_step  = take ? COUNT_BITS'(trial - {1'b0, job_reg.divisor})
                         : trial[COUNT_BITS-1:0];
        quo_step  = {quo_reg[SUM_BITS-2:0], take};
        last_step = step_reg == DIV_CNT_BITS'(SUM_BITS - 1);
        emit_ok   = !out_valid_reg || result_out.ready;
        load_out  = (state_reg == S_EMIT) && emit_ok;
    end

    assign job_pop = (state_reg == S_IDLE) && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            step_reg       <= '0;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_delta_reg  <= '0;
            out_done_reg   <= 1'b0;
            out_avg_reg    <= '0;
            out_frames_reg <= '0;
            out_sum_reg    <= '0;
        end
        else
        begin
            if (result_out.ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        rem_reg   <= '0;
                        quo_reg   <= job.dividend;
                        step_reg  <= '0;
                        state_reg <= job.done ? S_DIV : S_EMIT;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        avg_reg   <= (job_reg.divisor == '0) ? '0 : quo_step;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_delta_reg  <= job_reg.delta;
                        out_done_reg   <= job_reg.done;
                        out_avg_reg    <= avg_reg;
                        out_frames_reg <= job_reg.frames;
                        out_sum_reg    <= job_reg.sum;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.delta_us         = out_delta_reg;
    assign result_out.window_done      = out_done_reg;
    assign result_out.average_us       = out_avg_reg;
    assign result_out.frames_in_window = out_frames_reg;
    assign result_out.window_sum_us    = out_sum_reg;

    a_div_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> job_reg.done)
        else $error("divider running for a frame that closed no window");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg < DIV_CNT_BITS'(SUM_BITS)))
        else $error("divider step count overran");

    a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_ok) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded into output register");

endmodule

// ===== bench/tb_frame_time_window_average_top.sv =====
`timescale 1ns / 1ps

module tb_frame_time_window_average_top;
    import ftwa_pkg::*;

    // cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles of quiet after the last result, well past the divide latency
    localparam int DRAIN_CYCLES   = 50;

    // one result transaction, field for field
    typedef struct packed {
        logic [FIELD_BITS-1:0] delta;
        logic                  done;
        logic [SUM_BITS-1:0]   average;
        logic [COUNT_BITS-1:0] frames;
        logic [SUM_BITS-1:0]   sum;
    } frame_result_t;

    // window averager mirror plus the queue of results still owed by the block
    class frame_time_scoreboard;
        logic [FIELD_BITS-1:0] threshold;
        logic [STAMP_BITS-1:0] prev_stamp;
        logic [COUNT_BITS-1:0] frame_tally;
        logic [SUM_BITS-1:0]   time_sum;
        logic [SUM_BITS-1:0]   average;
        frame_result_t         owed[$];
        int                    errors;

        function new();
            threshold   = THRESHOLD_RESET;
            prev_stamp  = '0;
            frame_tally = '0;
            time_sum    = '0;
            average     = '0;
            errors      = 0;
        endfunction

        function void set_threshold(logic [FIELD_BITS-1:0] value);
            threshold = value;
        endfunction

        // accepted frame: advance the mirror and queue the result it must produce
        function void note_frame(logic [FIELD_BITS-1:0] stamp);
            frame_result_t       res;
            logic [STAMP_BITS-1:0] delta;
            logic [SUM_BITS:0]   wide_sum;
            delta      = stamp - prev_stamp;
            prev_stamp = stamp;
            if (frame_tally != COUNT_MAX)
                frame_tally = frame_tally + 1'b1;
            wide_sum = {1'b0, time_sum} + {{(SUM_BITS + 1 - STAMP_BITS){1'b0}}, delta};
            if (wide_sum > {1'b0, SUM_MAX})
                time_sum = SUM_MAX;
            else
                time_sum = wide_sum[SUM_BITS-1:0];
            res.done = 1'b0;
            if (time_sum >= {{(SUM_BITS - FIELD_BITS){1'b0}}, threshold})
            begin
                if (frame_tally != '0)
                    average = time_sum / {{(SUM_BITS - COUNT_BITS){1'b0}}, frame_tally};
                else
                    average = '0;
                time_sum    = '0;
                frame_tally = '0;
                res.done    = 1'b1;
            end
            res.delta   = delta;
            res.average = average;
            res.frames  = frame_tally;
            res.sum     = time_sum;
            owed.push_back(res);
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (owed.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: delta=%h done=%b avg=%h frames=%h sum=%h",
                             got.delta, got.done, got.average, got.frames, got.sum);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.delta !== want.delta || got.done !== want.done
                || got.average !== want.average || got.frames !== want.frames
                || got.sum !== want.sum)
            begin
                if (errors < 10)
                begin
                    $display("mismatch: expected delta=%h done=%b avg=%h frames=%h sum=%h",
                             want.delta, want.done, want.average, want.frames, want.sum);
                    $display("          actual   delta=%h done=%b avg=%h frames=%h sum=%h",
                             got.delta, got.done, got.average, got.frames, got.sum);
                end
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [FIELD_BITS-1:0] cfg_wr_data;

    ftwa_in_if  frame_if ();
    ftwa_out_if result_if ();

    frame_time_scoreboard sb = new();

    // idling knobs, percent of cycles, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off requested by the stimulus, taken over by the receiver
    int hold_request   = 0;

    // last timestamp offered, so random stamps can walk forward from it
    logic [FIELD_BITS-1:0] last_sent = '0;

    frame_time_window_average_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_if),
        .result_out  (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one frame; valid stays high from a previous transaction unless we idle
    task automatic send_frame(input logic [FIELD_BITS-1:0] stamp);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            if (!lowered)
            begin
                frame_if.valid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.now_stamp_us <= stamp;
        // the edge with ready high is the accepting one
        do
            @(posedge clk);
        while (!frame_if.ready);
        sb.note_frame(stamp);
        last_sent = stamp;
    endtask

    // called in the step of the last transaction of a sequence
    task automatic stop_frames();
        frame_if.valid <= 1'b0;
    endtask

    // all owed results back; every frame yields one, so the block is idle then
    task automatic wait_idle();
        while (sb.owed.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_threshold(input logic [FIELD_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_threshold(value);
    endtask

    // one random phase: threshold, step size of the timestamp walk, idling, length, receiver hold-off
    task automatic run_phase(input logic [FIELD_BITS-1:0] thr,
                             input logic [FIELD_BITS-1:0] step_max,
                             input int send_idle, input int recv_stall,
                             input int n_frames, input int hold);
        logic [FIELD_BITS-1:0] stamp;
        int                    pick;
        wait_idle();
        write_threshold(thr);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        hold_request   = hold;
        stamp = last_sent;
        for (int i = 0; i < n_frames; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                stamp = $urandom;                            // jump anywhere
            else if (pick < 12)
                stamp = stamp;                               // zero elapsed time
            else if (pick < 16)
                stamp = 32'hFFFF_FFF0 | $urandom_range(0, 15); // park near the wrap
            else
                stamp = stamp + $urandom_range(0, step_max);   // normal frame cadence
            send_frame(stamp);
        end
        stop_frames();
    endtask

    // receiver: check on accepting edges, then choose ready for the next cycle
    initial
    begin
        int hold_left;
        frame_result_t got;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.delta   = result_if.delta_us;
                got.done    = result_if.window_done;
                got.average = result_if.average_us;
                got.frames  = result_if.frames_in_window;
                got.sum     = result_if.window_sum_us;
                sb.check_result(got);
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                // long hold-off so the queue fills and input backs up
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: any transaction on either side resets the count
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [FIELD_BITS-1:0] directed_stamps [0:11];
        logic [FIELD_BITS-1:0] zero_thr_stamps [0:4];
        logic [FIELD_BITS-1:0] thr;

        // first frame is measured against the reset stamp of zero; window closing
        // past the threshold, max elapsed time and wrap-around follow
        directed_stamps = '{32'h0000_1234, 32'h0000_1298, 32'h0007_B354, 32'hFFFF_FFFF,
                            32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA};
        // with a zero threshold every frame closes, a zero delta averages to zero
        zero_thr_stamps = '{32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0001,
                            32'hFFFF_FFFE, 32'h0000_0000};

        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        frame_if.valid        <= 1'b0;
        frame_if.now_stamp_us <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset threshold
        foreach (directed_stamps[i])
            send_frame(directed_stamps[i]);
        stop_frames();

        wait_idle();
        write_threshold('0);
        foreach (zero_thr_stamps[i])
            send_frame(zero_thr_stamps[i]);
        stop_frames();

        // random part across thresholds and idling patterns
        run_phase(32'd1000, 32'd400, 0, 0, 180, 0);
        run_phase(32'd0, 32'd50, 84, 0, 150, 0);
        run_phase(32'd500000, 32'd200000, 0, 84, 180, 0);
        run_phase(32'hFFFF_FFFF, 32'h6000_0000, 10, 10, 180, 0);
        run_phase(32'd1, 32'd3, 0, 0, 150, 400);
        thr = $urandom_range(1, 1 << 20);
        run_phase(thr, thr / 3 + 1, 84, 0, 180, 0);
        run_phase(32'd37, 32'd20, 0, 84, 180, 0);
        thr = $urandom;
        run_phase(thr, thr / 3 + 1, 10, 10, 180, 0);

        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
